// ----- hw/rtl/clr_pkg.sv -----
// clr_pkg: shared types and constants for the configuration line reader
// holds the item/result payload structs, character codes and result kinds
// no dependencies
`default_nettype none

package clr_pkg;

	// register and field widths
	localparam int unsigned MAX_LINE_W = 12;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned KIND_W     = 2;

	// default line limit and reset value of max_line
	localparam int unsigned             LINE_LIMIT_DEF = 2048;
	localparam logic [MAX_LINE_W-1:0]   MAX_LINE_RST   = 12'd2048;

	// character codes
	localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
	localparam logic [CHAR_W-1:0] CH_BSL  = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
	localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_MID  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LAST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	typedef struct packed {
		logic [CHAR_W-1:0] in_byte;
		logic              end_of_input;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic [KIND_W-1:0] kind;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/config_line_reader.sv -----
// config_line_reader: cleans a raw configuration text byte stream into lines
// depends on clr_pkg (payload structs, character codes, result kinds)
`default_nettype none

// channel   direction  payload            transaction
// item      in         item_t             item_valid && item_ready
// result    out        result_t           result_valid && result_ready
// cfg       in         max_line (12 bit)  cfg_valid && cfg_ready (always ready)
//
// one item per cycle: each byte is decoded at acceptance by a few compares and
// the line counter update, and its results are written into a three-entry
// result queue; item_ready is high while the queue holds at most one entry
// an end-of-input item makes up to two results, so the sustained rate over a
// stream is set by the single-result-per-cycle queue output
// results appear on the port at the earliest in the cycle after the item's transaction
// reset (arst_n low) clears the line state, empties the queue and sets max_line to 2048

module config_line_reader
	import clr_pkg::*;
#(
	parameter int unsigned LINE_LIMIT = LINE_LIMIT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [MAX_LINE_W-1:0] cfg_data
);

	// line counter width: holds values up to LINE_LIMIT
	localparam int unsigned CW = $clog2(LINE_LIMIT + 1);
	// compare width for the counter against the limit in use
	localparam int unsigned LW = (CW > MAX_LINE_W) ? CW : MAX_LINE_W;
	localparam int unsigned QD = 3;

	// line state
	logic [MAX_LINE_W-1:0] max_line_q;
	logic [CW-1:0]         line_count_q, line_count_n;
	logic [CHAR_W-1:0]     held_char_q, held_char_n;
	logic                  escape_q, escape_n;
	logic                  comment_q, comment_n;

	// result queue, entry 0 is the head
	result_t    queue_q [QD];
	result_t    queue_n [QD];
	logic [1:0] fill_q, fill_n, fill_mid;

	logic       take;
	logic       pop;
	logic [1:0] push_cnt;
	result_t    push0, push1;

	logic [LW-1:0] limit;
	logic [LW-1:0] max_ext;

	assign cfg_ready    = 1'b1;
	assign item_ready   = ~fill_q[1];
	assign take         = item_valid & item_ready;
	assign result_valid = (fill_q != 2'd0);
	assign result       = queue_q[0];
	assign pop          = result_valid & result_ready;

	// limit in use is min(max_line, LINE_LIMIT)
	assign max_ext = LW'(max_line_q);
	assign limit   = (max_ext > LW'(LINE_LIMIT)) ? LW'(LINE_LIMIT) : max_ext;

	// byte decode and line state update
	always_comb begin
		logic [CHAR_W-1:0] ch;
		logic              esc_nl;
		logic              has_chars;

		line_count_n = line_count_q;
		held_char_n  = held_char_q;
		escape_n     = escape_q;
		comment_n    = comment_q;
		push_cnt     = 2'd0;
		push0        = '{out_char: held_char_q, kind: KIND_LAST};
		push1        = '{out_char: CH_NUL, kind: KIND_DONE};

		// tabs read as spaces, an escaped newline reads as a space
		ch        = (item.in_byte == CH_TAB) ? CH_SP : item.in_byte;
		esc_nl    = escape_q && (ch == CH_NL);
		has_chars = (line_count_q != '0);
		if (esc_nl) begin
			ch = CH_SP;
		end

		if (take) begin
			if (item.end_of_input) begin
				// flush the held character if the line has one, then mark the stream end
				if (has_chars) begin
					push_cnt = 2'd2;
				end else begin
					push0    = '{out_char: CH_NUL, kind: KIND_DONE};
					push_cnt = 2'd1;
				end
				line_count_n = '0;
				held_char_n  = CH_NUL;
				escape_n     = 1'b0;
				comment_n    = 1'b0;
			end else if (item.in_byte != CH_CR) begin
				escape_n = (ch == CH_BSL);
				if (comment_q) begin
					if (ch == CH_NL) begin
						comment_n = 1'b0;
					end
				end else if (!has_chars) begin
					if (ch == CH_HASH) begin
						comment_n = 1'b1;
					end else if (ch != CH_SP && ch != CH_NL) begin
						held_char_n  = ch;
						line_count_n = CW'(1);
					end
				end else if (esc_nl) begin
					// retraction: a lone character empties the line,
					// otherwise the held character becomes a space
					if (line_count_q == CW'(1)) begin
						line_count_n = '0;
					end else begin
						held_char_n = CH_SP;
					end
				end else if (ch == CH_NL) begin
					push_cnt     = 2'd1;
					line_count_n = '0;
					held_char_n  = CH_NUL;
				end else if (LW'(line_count_q) < limit) begin
					push0        = '{out_char: held_char_q, kind: KIND_MID};
					push_cnt     = 2'd1;
					held_char_n  = ch;
					line_count_n = line_count_q + CW'(1);
				end
			end
		end
	end

	// queue: shift out at the head, append behind the remaining entries
	always_comb begin
		queue_n  = queue_q;
		fill_mid = fill_q - {1'b0, pop};
		if (pop) begin
			for (int i = 0; i < QD - 1; i++) begin
				queue_n[i] = queue_q[i+1];
			end
		end
		for (int i = 0; i < QD; i++) begin
			if (push_cnt != 2'd0 && fill_mid == 2'(i)) begin
				queue_n[i] = push0;
			end
			if (push_cnt == 2'd2 && fill_mid + 2'd1 == 2'(i)) begin
				queue_n[i] = push1;
			end
		end
		fill_n = fill_mid + push_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q   <= MAX_LINE_RST;
			line_count_q <= '0;
			held_char_q  <= CH_NUL;
			escape_q     <= 1'b0;
			comment_q    <= 1'b0;
			fill_q       <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_line_q <= cfg_data;
			end
			line_count_q <= line_count_n;
			held_char_q  <= held_char_n;
			escape_q     <= escape_n;
			comment_q    <= comment_n;
			fill_q       <= fill_n;
		end
	end

	// queue payload carries no reset
	always_ff @(posedge clk) begin
		queue_q <= queue_n;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/clr_checker.sv -----
// clr_checker: port-level assertions for config_line_reader, bound to each of its instances
// depends on clr_pkg and on config_line_reader's port list
`default_nettype none

module clr_checker
	import clr_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  item_valid,
	input wire logic                  item_ready,
	input wire item_t                 item,
	input wire logic                  result_valid,
	input wire logic                  result_ready,
	input wire result_t               result,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [MAX_LINE_W-1:0] cfg_data
);

	// only the three defined kinds leave the block
	a_kind_known: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.kind == KIND_MID || result.kind == KIND_LAST ||
			result.kind == KIND_DONE))
		else $error("result kind outside the defined codes");

	// stream end carries a zero character
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_DONE |-> result.out_char == CH_NUL)
		else $error("stream end result with nonzero character");

	// an end-of-input transaction always leaves a result pending
	a_eoi_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.end_of_input |=> result_valid)
		else $error("no result after end of input");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// register writes are taken at once and carry defined data
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
		else $error("register write not taken or undefined");

endmodule

bind config_line_reader clr_checker u_clr_checker (.*);

`default_nettype wire
